[design/pcuv_pkg.sv]
// Shared types, codes and reset table of the PWM channel update verifier.
package pcuv_pkg;

   // Field widths
   localparam int CURSOR_W = 5;
   localparam int CHAN_W   = 4;
   localparam int VALUE_W  = 12;
   localparam int READ_W   = 16;
   localparam int ADDR_W   = 8;
   localparam int REQ_W    = 2;
   localparam int FUNC_W   = 2;

   // Item kinds
   localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DONE = 2'd2;

   // Bus request codes
   localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

   // Device register map: channel n sits at n*4 + ADDR_BASE
   localparam logic [ADDR_W-1:0] ADDR_BASE = 8'd8;

   // Default off counts
   localparam logic [VALUE_W-1:0] VALUE_HI = 12'd1500;
   localparam logic [VALUE_W-1:0] VALUE_LO = 12'd1000;

   typedef enum logic [1:0] {
      PH_INIT       = 2'd0,
      PH_WRITE_BUSY = 2'd1,
      PH_READ_BUSY  = 2'd2,
      PH_READY      = 2'd3
   } phase_type;

   typedef struct packed {
      logic [REQ_W-1:0]   bus_request;
      logic [ADDR_W-1:0]  reg_addr;
      logic [7:0]         data_low;
      logic [3:0]         data_high;
      logic               mismatch;
      logic               all_done;
   } result_type;

   // Off count loaded at reset: channels 0, 1 and 3 start high, the rest low
   function automatic logic [VALUE_W-1:0] reset_value(input int unsigned idx);
      logic [VALUE_W-1:0] v;
      v = VALUE_LO;
      if (idx == 0 || idx == 1 || idx == 3) begin
         v = VALUE_HI;
      end
      return v;
   endfunction

endpackage

[design/pcuv_pick.sv]
// Priority encoder: lowest pending channel at or above a start index.
module pcuv_pick #(
   parameter int CHANNELS = 16
) (
   input  logic [CHANNELS-1:0]           marks,
   input  logic [pcuv_pkg::CURSOR_W-1:0] from,
   output logic [pcuv_pkg::CURSOR_W-1:0] index
);
   import pcuv_pkg::*;

   // Scan from the top so the lowest hit wins; CHANNELS means none found
   always_comb begin
      index = CURSOR_W'(CHANNELS);
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (marks[i] && (CURSOR_W'(i) >= from)) begin
            index = CURSOR_W'(i);
         end
      end
   end

endmodule

[design/pcuv_ctrl.sv]
// Channel table, pending marks, cursor and phase with the per-item update logic.
module pcuv_ctrl #(
   parameter int CHANNELS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [pcuv_pkg::FUNC_W-1:0]   func,
   input  logic [pcuv_pkg::CHAN_W-1:0]   channel,
   input  logic [pcuv_pkg::VALUE_W-1:0]  value,
   input  logic                          bus_ok,
   input  logic [pcuv_pkg::READ_W-1:0]   read_data,
   output pcuv_pkg::result_type          result
);
   import pcuv_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CURSOR_W-1:0] CUR_END = CURSOR_W'(CHANNELS);

   logic [CHANNELS-1:0] pending_ff, pending_in;
   logic [VALUE_W-1:0]  value_ff [CHANNELS];
   logic [VALUE_W-1:0]  value_in [CHANNELS];
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   phase_type           phase_ff, phase_in;

   logic [CURSOR_W-1:0] first_any;
   logic [CURSOR_W-1:0] first_next;
   logic [CURSOR_W-1:0] cursor_plus;
   logic [CURSOR_W-1:0] tick_cur;
   phase_type           tick_phase;
   logic                rescan;
   logic [VALUE_W-1:0]  cur_value;

   assign cursor_plus = cursor_ff + CURSOR_W'(1);

   pcuv_pick #(.CHANNELS(CHANNELS)) u_pick_any (
      .marks (pending_ff),
      .from  ('0),
      .index (first_any)
   );

   pcuv_pick #(.CHANNELS(CHANNELS)) u_pick_next (
      .marks (pending_ff),
      .from  (cursor_plus),
      .index (first_next)
   );

   // Tick: reselect the cursor when it ran off the end or after init
   always_comb begin
      rescan     = (cursor_ff >= CUR_END) || (phase_ff == PH_INIT);
      tick_cur   = rescan ? first_any : cursor_ff;
      tick_phase = phase_ff;
      if (rescan && (first_any < CUR_END)) begin
         tick_phase = PH_READY;
      end
   end

   // Single table read port, addressed by the tick cursor or the live cursor
   assign cur_value = (func == FUNC_TICK) ? value_ff[tick_cur[IDX_W-1:0]]
                                          : value_ff[cursor_ff[IDX_W-1:0]];

   // Next state and result for the item
   always_comb begin
      pending_in = pending_ff;
      value_in   = value_ff;
      cursor_in  = cursor_ff;
      phase_in   = phase_ff;
      result     = '0;

      unique case (func)
         FUNC_SET: begin
            if ({1'b0, channel} < CUR_END) begin
               value_in[channel[IDX_W-1:0]]   = value;
               pending_in[channel[IDX_W-1:0]] = 1'b1;
            end
         end
         FUNC_TICK: begin
            cursor_in = tick_cur;
            phase_in  = tick_phase;
            if ((tick_cur < CUR_END) && (tick_phase == PH_READY)) begin
               result.bus_request = REQ_WRITE;
               result.reg_addr    = {1'b0, tick_cur, 2'b00} + ADDR_BASE;
               result.data_low    = cur_value[7:0];
               result.data_high   = cur_value[11:8];
               phase_in           = PH_WRITE_BUSY;
            end
         end
         FUNC_DONE: begin
            if (bus_ok && (cursor_ff < CUR_END)) begin
               if (phase_ff == PH_WRITE_BUSY) begin
                  result.bus_request = REQ_READ;
                  result.reg_addr    = {1'b0, cursor_ff, 2'b00} + ADDR_BASE;
                  phase_in           = PH_READ_BUSY;
               end else if (phase_ff == PH_READ_BUSY) begin
                  if (read_data != {{(READ_W-VALUE_W){1'b0}}, cur_value}) begin
                     result.mismatch = 1'b1;
                  end else begin
                     phase_in                          = PH_READY;
                     pending_in[cursor_ff[IDX_W-1:0]] = 1'b0;
                     cursor_in                         = first_next;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      result.all_done = (cursor_in >= CUR_END);
   end

   // State registers, loaded with the default table at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '1;
         for (int i = 0; i < CHANNELS; i++) begin
            value_ff[i] <= reset_value(i);
         end
         cursor_ff <= '0;
         phase_ff  <= PH_INIT;
      end else if (accept) begin
         pending_ff <= pending_in;
         value_ff   <= value_in;
         cursor_ff  <= cursor_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

[design/pwm_channel_update_verifier.sv]
// Each accepted item's result is registered and appears on the rsp channel in the next cycle.
// Throughput: one item per cycle while rsp is not stalled; the table, marks, cursor and phase update in one pass.
// req_tready drops only while a result is held and rsp_tready is low.
// Reset (synchronous): all channels pending, default counts loaded, cursor 0,
// phase init, output register empty.
module pwm_channel_update_verifier #(
   parameter int CHANNELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // channel[3:0], value[15:4], bus_ok[16], read_data[32:17]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // reg_addr[7:0], data_low[15:8], data_high[19:16],
                                    // mismatch[20], all_done[21]
   output logic [1:0]  rsp_tuser    // bus_request[1:0]
);
   import pcuv_pkg::*;

   logic       accept;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;

   // Take an item whenever the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   pcuv_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_tuser),
      .channel   (req_tdata[3:0]),
      .value     (req_tdata[15:4]),
      .bus_ok    (req_tdata[16]),
      .read_data (req_tdata[32:17]),
      .result    (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.bus_request;
   assign rsp_tdata  = {2'b00, rsp_data_ff.all_done, rsp_data_ff.mismatch,
                        rsp_data_ff.data_high, rsp_data_ff.data_low, rsp_data_ff.reg_addr};

   // Every accepted item yields a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // A request always targets a live channel, so the cursor is in range
   a_request_not_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != REQ_NONE) |-> !rsp_tdata[21])
      else $error("bus request issued with cursor past the end");

   // A mismatch is reported only on a result without a request
   a_mismatch_no_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[20]) |-> (rsp_tuser == REQ_NONE))
      else $error("mismatch flagged together with a bus request");

   // No request means no address and no data
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == REQ_NONE) |-> (rsp_tdata[19:0] == '0))
      else $error("address or data set without a request");

   // A readback carries an address but no write data
   a_read_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == REQ_READ) |-> (rsp_tdata[19:8] == '0))
      else $error("readback request carries write data");

endmodule
